// File: rtl/pts_pkg.sv
// Shared types and constants for the pyramid translation search block.
`default_nettype none

package pts_pkg;

  localparam int INK_BITS      = 12;
  localparam int GRID_REG_BITS = 7;
  localparam int STEP_BITS     = 11;
  localparam int STEP_MAX      = 1024;
  localparam int CFG_DATA_BITS = 11;
  localparam int CFG_IDX_BITS  = 2;
  localparam int SHIFT_BITS    = 18;
  localparam int MIN_SIDE      = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_CELL_STEP   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_BLUR_H,
    ST_BLUR_V,
    ST_GROW,
    ST_HALVE,
    ST_LVL_SETUP,
    ST_CAND,
    ST_AGREE,
    ST_CAND_DONE,
    ST_LVL_DONE,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// File: rtl/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pts_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/pyramid_translation_search.sv
// Top level: grid loader, pyramid builder and coarse-to-fine translation search.
//
// Input channel (in_valid_i/in_ready_o): one word carries one cell of each grid
// in raster order; a word is taken every cycle while loading. A word with
// last_cell_i set starts the search, and in_ready_o stays low until it ends.
// Search time depends on grid size: blur walks every cell in each pass,
// halving every coarse cell, and each candidate shift every cell, with a
// shorter step for a cell outside the overlap; all through one adder/multiplier
// and one read port per memory.
// Output channel (out_valid_o/out_ready_i): one word per last_cell word, held
// in an output register; a stalled receiver holds the next search result
// until the register frees, and no new raster is loaded meanwhile.
// Config port: write cfg_data_i to register cfg_idx_i while cfg_we_i is high;
// only while idle. Reset returns the registers to 96, 96, 1 and empties the
// load counters; the grid memories are not cleared.
`default_nettype none

module pyramid_translation_search #(
  parameter int MAX_CELLS_ACROSS = 96,
  parameter int TOP_LEVEL_SIDE   = 12,
  parameter int REFINE_REACH     = 2
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pts_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [pts_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [pts_pkg::INK_BITS-1:0]        before_ink_i,
  input  wire logic [pts_pkg::INK_BITS-1:0]        after_ink_i,
  input  wire logic                                last_cell_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [pts_pkg::SHIFT_BITS-1:0]    shift_x_o,
  output logic signed [pts_pkg::SHIFT_BITS-1:0]    shift_y_o,
  output logic                                     searched_o
);

  localparam int IB        = pts_pkg::INK_BITS;
  localparam int DW        = $clog2(MAX_CELLS_ACROSS + 1);
  localparam int CELLS     = MAX_CELLS_ACROSS * MAX_CELLS_ACROSS;
  localparam int CW        = $clog2(CELLS + 1);
  localparam int SAW       = $clog2(CELLS);
  localparam int PYR_DEPTH = (CELLS * 4) / 3 + 4;
  localparam int PAW       = $clog2(PYR_DEPTH);
  localparam int LVL_N     = $clog2(MAX_CELLS_ACROSS) + 1;
  localparam int LW        = $clog2(LVL_N);
  localparam int DXW       = DW + 3;
  localparam int EW        = DXW + 1;
  localparam int SOW       = DXW + DW + 1;
  localparam int AGW       = ((PAW > SOW) ? PAW : SOW) + 2;
  localparam int ACW       = IB + 2;
  localparam int ACCW      = 2 * IB + CW;
  localparam int TOTW      = IB + CW;
  localparam int SB        = pts_pkg::STEP_BITS;
  localparam int PXW       = DXW + SB + 1;
  localparam int GRB       = pts_pkg::GRID_REG_BITS;
  localparam logic [TOTW-1:0] INK_UNIT = TOTW'(1) << IB;

  pts_pkg::state_e state_q, state_d;

  logic [GRB-1:0] cfg_w_q, cfg_h_q;
  logic [SB-1:0]  cfg_step_q;

  logic [DW-1:0]   grid_w, grid_h;
  logic [CW-1:0]   cells;
  logic [SB-1:0]   step;

  logic [CW-1:0]   cnt_q;
  logic [TOTW-1:0] tot_b_q, tot_a_q;
  logic            img_q, srch_q, center_q;
  logic [2:0]      ph_q;
  logic [DW-1:0]   x_q, y_q, cw_q, ch_q, fw_q;
  logic [CW-1:0]   rb_q, fb_q;
  logic [PAW-1:0]  off_q, noff_q;
  logic [ACW-1:0]  acc_q;
  logic [2*IB-1:0] prod_q;
  logic [ACCW-1:0] sacc_q, score_q;
  logic [DW-1:0]   lw_q [LVL_N];
  logic [DW-1:0]   lh_q [LVL_N];
  logic [PAW-1:0]  loff_q [LVL_N];
  logic [LW-1:0]   top_q, lvl_q;
  logic signed [DXW-1:0] cx_q, cy_q, rx_q, ry_q, dx_q, dy_q, fx_q, fy_q, bdx_q, bdy_q;
  logic signed [SOW-1:0] so_q;
  logic            out_valid_q, searched_q;
  logic [pts_pkg::SHIFT_BITS-1:0] shift_x_q, shift_y_q;

  logic [IB-1:0]  bp_rdata, ap_rdata, sc_rdata, img_rd, rd;
  logic [PAW-1:0] rd_addr, bp_raddr, ap_raddr, p_waddr, sh_addr, own_addr;
  logic [IB-1:0]  bp_wdata, ap_wdata, res;
  logic           bp_we, ap_we, s_we, wr_img, load_acc;
  logic [SAW-1:0] s_raddr, s_waddr;
  logic [ACW-1:0] acc_base, addend, sum;
  logic           last_x, last_y, elem_done, elem_step;
  logic [DW-1:0]  nx, ny, xm1, xp1, col;
  logic [CW-1:0]  nrb, nfb, vrow;
  logic signed [EW-1:0] sx, sy;
  logic           ov_ok, grow_ok, chk_ok, is_top, cand_last;
  logic signed [DXW-1:0] cx_n, cy_n;
  logic [AGW-1:0] sh_full;
  logic signed [PXW-1:0] prod_x, prod_y;

  // config clamps
  always_comb begin
    if (cfg_w_q == '0) grid_w = DW'(1);
    else if (32'(cfg_w_q) > MAX_CELLS_ACROSS) grid_w = DW'(MAX_CELLS_ACROSS);
    else grid_w = DW'(cfg_w_q);
    if (cfg_h_q == '0) grid_h = DW'(1);
    else if (32'(cfg_h_q) > MAX_CELLS_ACROSS) grid_h = DW'(MAX_CELLS_ACROSS);
    else grid_h = DW'(cfg_h_q);
    if (cfg_step_q == '0) step = SB'(1);
    else if (32'(cfg_step_q) > pts_pkg::STEP_MAX) step = SB'(pts_pkg::STEP_MAX);
    else step = cfg_step_q;
  end

  assign cells    = CW'(grid_w) * CW'(grid_h);
  assign load_acc = (state_q == pts_pkg::ST_LOAD) && in_valid_i;
  assign chk_ok   = (32'(grid_w) >= pts_pkg::MIN_SIDE) && (32'(grid_h) >= pts_pkg::MIN_SIDE) &&
                    (tot_b_q >= INK_UNIT) && (tot_a_q >= INK_UNIT);
  assign grow_ok  = (32'(cw_q) > TOP_LEVEL_SIDE) && (32'(ch_q) > TOP_LEVEL_SIDE);
  assign is_top   = (lvl_q == top_q);
  assign cx_n     = is_top ? bdx_q : (bdx_q <<< 1);
  assign cy_n     = is_top ? bdy_q : (bdy_q <<< 1);
  assign cand_last = !center_q && (dx_q == cx_q + rx_q) && (dy_q == cy_q + ry_q);

  // element walk
  assign last_x    = (x_q == cw_q - DW'(1));
  assign last_y    = (y_q == ch_q - DW'(1));
  assign elem_done = last_x && last_y;
  assign nx        = last_x ? '0 : x_q + DW'(1);
  assign ny        = last_x ? y_q + DW'(1) : y_q;
  assign nrb       = last_x ? rb_q + CW'(cw_q) : rb_q;
  assign nfb       = last_x ? fb_q + (CW'(fw_q) << 1) : fb_q;
  assign xm1       = (x_q == '0) ? x_q : x_q - DW'(1);
  assign xp1       = last_x ? x_q : x_q + DW'(1);

  assign sx    = $signed(EW'(x_q)) - dx_q;
  assign sy    = $signed(EW'(y_q)) - dy_q;
  assign ov_ok = (sx >= 0) && (sx < $signed(EW'(cw_q))) &&
                 (sy >= 0) && (sy < $signed(EW'(ch_q)));

  always_comb begin
    case (state_q)
      pts_pkg::ST_BLUR_H, pts_pkg::ST_BLUR_V: elem_step = (ph_q == 3'd3);
      pts_pkg::ST_HALVE:                      elem_step = (ph_q == 3'd4);
      pts_pkg::ST_AGREE: elem_step = ((ph_q == 3'd0) && !ov_ok) || (ph_q == 3'd2);
      default:                                elem_step = 1'b0;
    endcase
  end

  // shared blur / average adder
  assign img_rd   = img_q ? ap_rdata : bp_rdata;
  assign rd       = (state_q == pts_pkg::ST_BLUR_V) ? sc_rdata : img_rd;
  assign acc_base = (ph_q == 3'd1) ? ACW'(2) : acc_q;
  assign addend   = ((state_q != pts_pkg::ST_HALVE) && (ph_q == 3'd2)) ?
                    (ACW'(rd) << 1) : ACW'(rd);
  assign sum      = acc_base + addend;
  assign res      = sum[IB+1:2];

  // addresses
  always_comb begin
    case (ph_q)
      3'd0:    col = xm1;
      3'd1:    col = x_q;
      default: col = xp1;
    endcase
    case (ph_q)
      3'd0:    vrow = (y_q == '0) ? rb_q : rb_q - CW'(cw_q);
      3'd1:    vrow = rb_q;
      default: vrow = last_y ? rb_q : rb_q + CW'(cw_q);
    endcase
    if (state_q == pts_pkg::ST_HALVE) begin
      case (ph_q)
        3'd0:    rd_addr = off_q + PAW'(fb_q) + (PAW'(x_q) << 1);
        3'd1:    rd_addr = off_q + PAW'(fb_q) + (PAW'(x_q) << 1) + PAW'(1);
        3'd2:    rd_addr = off_q + PAW'(fb_q) + (PAW'(x_q) << 1) + PAW'(fw_q);
        default: rd_addr = off_q + PAW'(fb_q) + (PAW'(x_q) << 1) + PAW'(fw_q) + PAW'(1);
      endcase
    end else begin
      rd_addr = off_q + PAW'(rb_q) + PAW'(col);
    end
  end

  assign own_addr = off_q + PAW'(rb_q) + PAW'(x_q);
  assign sh_full  = AGW'(off_q) + AGW'(rb_q) + AGW'(x_q) - AGW'(so_q);
  assign sh_addr  = sh_full[PAW-1:0];
  assign bp_raddr = (state_q == pts_pkg::ST_AGREE) ? sh_addr : rd_addr;
  assign ap_raddr = (state_q == pts_pkg::ST_AGREE) ? own_addr : rd_addr;
  assign s_raddr  = SAW'(vrow + CW'(x_q));
  assign s_waddr  = SAW'(rb_q + CW'(x_q));
  assign s_we     = (state_q == pts_pkg::ST_BLUR_H) && (ph_q == 3'd3);

  assign wr_img   = ((state_q == pts_pkg::ST_BLUR_V) && (ph_q == 3'd3)) ||
                    ((state_q == pts_pkg::ST_HALVE) && (ph_q == 3'd4));
  assign p_waddr  = (state_q == pts_pkg::ST_LOAD) ? PAW'(cnt_q) :
                    (state_q == pts_pkg::ST_HALVE) ? noff_q + PAW'(rb_q) + PAW'(x_q) : own_addr;
  assign bp_we    = (load_acc && (cnt_q < cells)) || (wr_img && !img_q);
  assign ap_we    = (load_acc && (cnt_q < cells)) || (wr_img && img_q);
  assign bp_wdata = (state_q == pts_pkg::ST_LOAD) ? before_ink_i : res;
  assign ap_wdata = (state_q == pts_pkg::ST_LOAD) ? after_ink_i : res;

  pts_ram #(.WIDTH(IB), .DEPTH(PYR_DEPTH)) u_bp_ram (
    .clk_i, .we_i(bp_we), .waddr_i(p_waddr), .wdata_i(bp_wdata),
    .raddr_i(bp_raddr), .rdata_o(bp_rdata)
  );

  pts_ram #(.WIDTH(IB), .DEPTH(PYR_DEPTH)) u_ap_ram (
    .clk_i, .we_i(ap_we), .waddr_i(p_waddr), .wdata_i(ap_wdata),
    .raddr_i(ap_raddr), .rdata_o(ap_rdata)
  );

  pts_ram #(.WIDTH(IB), .DEPTH(CELLS)) u_sc_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(res),
    .raddr_i(s_raddr), .rdata_o(sc_rdata)
  );

  assign prod_x = bdx_q * $signed({1'b0, step});
  assign prod_y = bdy_q * $signed({1'b0, step});

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = (state_q == pts_pkg::ST_LOAD);
    case (state_q)
      pts_pkg::ST_LOAD:      if (in_valid_i && last_cell_i) state_d = pts_pkg::ST_CHECK;
      pts_pkg::ST_CHECK:     state_d = chk_ok ? pts_pkg::ST_BLUR_H : pts_pkg::ST_FINISH;
      pts_pkg::ST_BLUR_H:    if (elem_step && elem_done) state_d = pts_pkg::ST_BLUR_V;
      pts_pkg::ST_BLUR_V: begin
        if (elem_step && elem_done) state_d = img_q ? pts_pkg::ST_GROW : pts_pkg::ST_BLUR_H;
      end
      pts_pkg::ST_GROW:      state_d = grow_ok ? pts_pkg::ST_HALVE : pts_pkg::ST_LVL_SETUP;
      pts_pkg::ST_HALVE: begin
        if (elem_step && elem_done) state_d = img_q ? pts_pkg::ST_BLUR_H : pts_pkg::ST_HALVE;
      end
      pts_pkg::ST_LVL_SETUP: state_d = pts_pkg::ST_CAND;
      pts_pkg::ST_CAND:      state_d = pts_pkg::ST_AGREE;
      pts_pkg::ST_AGREE:     if (elem_step && elem_done) state_d = pts_pkg::ST_CAND_DONE;
      pts_pkg::ST_CAND_DONE: state_d = cand_last ? pts_pkg::ST_LVL_DONE : pts_pkg::ST_CAND;
      pts_pkg::ST_LVL_DONE: begin
        state_d = (lvl_q == '0) ? pts_pkg::ST_FINISH : pts_pkg::ST_LVL_SETUP;
      end
      pts_pkg::ST_FINISH:    if (!out_valid_q) state_d = pts_pkg::ST_LOAD;
      default:               state_d = pts_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= GRB'(96);
      cfg_h_q     <= GRB'(96);
      cfg_step_q  <= SB'(1);
      cnt_q       <= '0;
      tot_b_q     <= '0;
      tot_a_q     <= '0;
      img_q       <= 1'b0;
      srch_q      <= 1'b0;
      center_q    <= 1'b0;
      ph_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      rb_q        <= '0;
      fb_q        <= '0;
      top_q       <= '0;
      lvl_q       <= '0;
      bdx_q       <= '0;
      bdy_q       <= '0;
      score_q     <= '0;
      out_valid_q <= 1'b0;
      searched_q  <= 1'b0;
      shift_x_q   <= '0;
      shift_y_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pts_pkg::CFG_GRID_WIDTH:  cfg_w_q    <= cfg_data_i[GRB-1:0];
          pts_pkg::CFG_GRID_HEIGHT: cfg_h_q    <= cfg_data_i[GRB-1:0];
          pts_pkg::CFG_CELL_STEP:   cfg_step_q <= cfg_data_i[SB-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        pts_pkg::ST_LOAD: begin
          if (load_acc && (cnt_q < cells)) begin
            cnt_q   <= cnt_q + CW'(1);
            tot_b_q <= tot_b_q + TOTW'(before_ink_i);
            tot_a_q <= tot_a_q + TOTW'(after_ink_i);
          end
        end
        pts_pkg::ST_CHECK: begin
          cnt_q     <= '0;
          tot_b_q   <= '0;
          tot_a_q   <= '0;
          srch_q    <= chk_ok;
          bdx_q     <= '0;
          bdy_q     <= '0;
          score_q   <= '0;
          cw_q      <= grid_w;
          ch_q      <= grid_h;
          off_q     <= '0;
          lw_q[0]   <= grid_w;
          lh_q[0]   <= grid_h;
          loff_q[0] <= '0;
          top_q     <= '0;
          img_q     <= 1'b0;
          ph_q      <= '0;
          x_q       <= '0;
          y_q       <= '0;
          rb_q      <= '0;
          fb_q      <= '0;
        end
        pts_pkg::ST_BLUR_H, pts_pkg::ST_BLUR_V, pts_pkg::ST_HALVE, pts_pkg::ST_AGREE: begin
          acc_q <= sum;
          if (state_q == pts_pkg::ST_AGREE) begin
            if (ph_q == 3'd1) prod_q <= bp_rdata * ap_rdata;
            if (ph_q == 3'd2) sacc_q <= sacc_q + ACCW'(prod_q);
          end
          if (elem_step) begin
            ph_q <= '0;
            x_q  <= nx;
            y_q  <= ny;
            rb_q <= nrb;
            fb_q <= nfb;
            if (elem_done) begin
              y_q  <= '0;
              rb_q <= '0;
              fb_q <= '0;
              if (state_q == pts_pkg::ST_BLUR_V) begin
                img_q <= !img_q;
              end
              if (state_q == pts_pkg::ST_HALVE) begin
                img_q <= !img_q;
                if (img_q) begin
                  top_q                 <= top_q + LW'(1);
                  lw_q[top_q + LW'(1)]   <= cw_q;
                  lh_q[top_q + LW'(1)]   <= ch_q;
                  loff_q[top_q + LW'(1)] <= noff_q;
                  off_q                 <= noff_q;
                end
              end
            end
          end else if ((state_q == pts_pkg::ST_AGREE) && (ph_q == 3'd0)) begin
            ph_q <= 3'd1;
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        pts_pkg::ST_GROW: begin
          if (grow_ok) begin
            fw_q   <= cw_q;
            cw_q   <= cw_q >> 1;
            ch_q   <= ch_q >> 1;
            noff_q <= off_q + PAW'(cw_q) * PAW'(ch_q);
          end else begin
            lvl_q <= top_q;
          end
        end
        pts_pkg::ST_LVL_SETUP: begin
          cw_q     <= lw_q[lvl_q];
          ch_q     <= lh_q[lvl_q];
          off_q    <= loff_q[lvl_q];
          rx_q     <= is_top ? $signed(DXW'(lw_q[lvl_q])) : DXW'(REFINE_REACH);
          ry_q     <= is_top ? $signed(DXW'(lh_q[lvl_q])) : DXW'(REFINE_REACH);
          cx_q     <= cx_n;
          cy_q     <= cy_n;
          dx_q     <= cx_n;
          dy_q     <= cy_n;
          fx_q     <= cx_n;
          fy_q     <= cy_n;
          center_q <= 1'b1;
        end
        pts_pkg::ST_CAND: begin
          so_q   <= (dy_q * $signed({1'b0, cw_q})) + SOW'(dx_q);
          ph_q   <= '0;
          x_q    <= '0;
          y_q    <= '0;
          rb_q   <= '0;
          sacc_q <= '0;
        end
        pts_pkg::ST_CAND_DONE: begin
          if (center_q) begin
            score_q  <= sacc_q;
            center_q <= 1'b0;
            dx_q     <= cx_q - rx_q;
            dy_q     <= cy_q - ry_q;
          end else begin
            if (sacc_q > score_q) begin
              score_q <= sacc_q;
              fx_q    <= dx_q;
              fy_q    <= dy_q;
            end
            if (dx_q == cx_q + rx_q) begin
              dx_q <= cx_q - rx_q;
              dy_q <= dy_q + DXW'(1);
            end else begin
              dx_q <= dx_q + DXW'(1);
            end
          end
        end
        pts_pkg::ST_LVL_DONE: begin
          bdx_q <= fx_q;
          bdy_q <= fy_q;
          if (lvl_q != '0) lvl_q <= lvl_q - LW'(1);
        end
        pts_pkg::ST_FINISH: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            searched_q  <= srch_q;
            shift_x_q   <= prod_x[pts_pkg::SHIFT_BITS-1:0];
            shift_y_q   <= prod_y[pts_pkg::SHIFT_BITS-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign searched_o  = searched_q;
  assign shift_x_o   = $signed(shift_x_q);
  assign shift_y_o   = $signed(shift_y_q);

endmodule

`default_nettype wire
